>>> rtl/epr_pkg.sv
package epr_pkg;

    // default sizing
    localparam int MAX_POINTS_DEF = 16;
    localparam int CORDIC_ITER_DEF = 24;

    // datapath widths
    localparam int LAT_W = 33;
    localparam int ANG_W = 36;
    localparam int CW = 56;
    localparam int TRIG_W = 32;
    localparam int MUL_W = 35;
    localparam int PROD_W = 70;
    localparam int CNT_W = 5;

    // cordic rotation start value, 0.60725293 in Q30
    localparam logic signed [CW-1:0] GAIN_Q30 = 56'sd652032874;

    // configuration register indexes
    localparam logic [3:0] CFG_CENTRE_X = 4'd0;
    localparam logic [3:0] CFG_CENTRE_Y = 4'd1;
    localparam logic [3:0] CFG_DIST_X = 4'd2;
    localparam logic [3:0] CFG_DIST_Y = 4'd3;
    localparam logic [3:0] CFG_OFFSET_X = 4'd4;
    localparam logic [3:0] CFG_OFFSET_Y = 4'd5;
    localparam logic [3:0] CFG_PITCH = 4'd6;
    localparam logic [3:0] CFG_REF_RADIUS = 4'd7;

    typedef struct packed {
        logic [23:0] front_edge_x;
        logic [23:0] fall_edge_x;
        logic [23:0] front_edge_y;
        logic [23:0] fall_edge_y;
        logic        last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] radius_x;
        logic signed [31:0] radius_y;
        logic [30:0]        rms_error;
        logic               rms_valid;
        logic               math_fault;
    } res_item_t;

    // lateral positions, Q.8 length units
    typedef struct packed {
        logic signed [LAT_W-1:0] lat_fx;
        logic signed [LAT_W-1:0] lat_lx;
        logic signed [LAT_W-1:0] lat_fy;
        logic signed [LAT_W-1:0] lat_ly;
        logic                    last_point;
    } mid_item_t;

    // atan(2^-i) in Q30
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = 36'sd843314857;
            5'd1:    r = 36'sd497837829;
            5'd2:    r = 36'sd263043837;
            5'd3:    r = 36'sd133525159;
            5'd4:    r = 36'sd67021687;
            5'd5:    r = 36'sd33543516;
            5'd6:    r = 36'sd16775851;
            5'd7:    r = 36'sd8388437;
            5'd8:    r = 36'sd4194283;
            5'd9:    r = 36'sd2097149;
            5'd10:   r = 36'sd1048576;
            5'd31:   r = '0;
            default: r = ANG_W'(1) << (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage

>>> rtl/epr_fifo.sv
module epr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/epr_front.sv
module epr_front (
    input  logic                push,
    output logic                full,
    input  epr_pkg::in_item_t   item,
    input  logic [23:0]         centre_x,
    input  logic [23:0]         centre_y,
    input  logic [23:0]         pitch,
    input  logic                mid_full,
    output logic                mid_wr,
    output epr_pkg::mid_item_t  mid_item
);
    // (edge - centre) * pitch, floored to Q.8
    function automatic logic signed [epr_pkg::LAT_W-1:0] lateral(
        input logic [23:0] edge_v,
        input logic [23:0] centre_v,
        input logic [23:0] pitch_v
    );
        logic signed [24:0] d;
        logic signed [49:0] p;
        d = $signed({1'b0, edge_v}) - $signed({1'b0, centre_v});
        p = d * $signed({1'b0, pitch_v});
        return p[48:16];
    endfunction

    // accept a beat whenever the middle queue has room
    assign full = mid_full;
    assign mid_wr = push && !mid_full;

    // map the front and fall edges of both axes to lateral positions
    always_comb
    begin
        mid_item.lat_fx = lateral(item.front_edge_x, centre_x, pitch);
        mid_item.lat_lx = lateral(item.fall_edge_x, centre_x, pitch);
        mid_item.lat_fy = lateral(item.front_edge_y, centre_y, pitch);
        mid_item.lat_ly = lateral(item.fall_edge_y, centre_y, pitch);
        mid_item.last_point = item.last_point;
    end

endmodule

>>> rtl/epr_cordic.sv
module epr_cordic #(
    parameter int CORDIC_ITERATIONS = epr_pkg::CORDIC_ITER_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              vec_mode,
    input  logic signed [epr_pkg::CW-1:0]     x0,
    input  logic signed [epr_pkg::CW-1:0]     y0,
    input  logic signed [epr_pkg::ANG_W-1:0]  z0,
    output logic                              busy,
    output logic                              done,
    output logic signed [epr_pkg::CW-1:0]     x,
    output logic signed [epr_pkg::CW-1:0]     y,
    output logic signed [epr_pkg::ANG_W-1:0]  z
);
    localparam int IW = $clog2(CORDIC_ITERATIONS);

    logic signed [epr_pkg::CW-1:0]    x_reg;
    logic signed [epr_pkg::CW-1:0]    y_reg;
    logic signed [epr_pkg::ANG_W-1:0] z_reg;
    logic [IW-1:0]                    i_reg;
    logic                             mode_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic signed [epr_pkg::CW-1:0]    sx;
    logic signed [epr_pkg::CW-1:0]    sy;
    logic signed [epr_pkg::ANG_W-1:0] step_ang;
    logic                             cw;

    assign busy = busy_reg;
    assign done = done_reg;
    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;

    // one micro-rotation per cycle
    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;
    assign step_ang = epr_pkg::atan_step(5'(i_reg));
    assign cw = mode_reg ? y_reg[epr_pkg::CW-1] : !z_reg[epr_pkg::ANG_W-1];

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x0;
            y_reg <= y0;
            z_reg <= z0;
            mode_reg <= vec_mode;
        end
        else if (busy_reg)
        begin
            if (cw)
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - step_ang;
            end
            else
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + step_ang;
            end
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(CORDIC_ITERATIONS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/epr_divider.sv
module epr_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quot_reg;
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quot_reg;

    // restoring step, one quotient bit per cycle
    assign rem_sh = {rem_reg, quot_reg[63]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign ge = (rem_sh >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[62:0], ge};
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/epr_back.sv
module epr_back #(
    parameter int MAX_POINTS = epr_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_ITERATIONS = epr_pkg::CORDIC_ITER_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mid_empty,
    input  epr_pkg::mid_item_t  mid_item,
    output logic                mid_pop,
    input  logic                out_full,
    output logic                out_wr,
    output epr_pkg::res_item_t  out_item,
    input  logic [30:0]         dist_x,
    input  logic [30:0]         dist_y,
    input  logic signed [31:0]  off_x,
    input  logic signed [31:0]  off_y,
    input  logic [30:0]         ref_radius
);
    localparam int AW = epr_pkg::ANG_W;
    localparam int AW1 = epr_pkg::ANG_W + 1;
    localparam int CW = epr_pkg::CW;
    localparam int TW = epr_pkg::TRIG_W;
    localparam int MW = epr_pkg::MUL_W;
    localparam int PW = epr_pkg::PROD_W;
    localparam int NW = epr_pkg::CNT_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_VEC_GO = 4'd1;
    localparam logic [3:0] ST_VEC_WAIT = 4'd2;
    localparam logic [3:0] ST_ROT_GO = 4'd3;
    localparam logic [3:0] ST_ROT_WAIT = 4'd4;
    localparam logic [3:0] ST_MUL = 4'd5;
    localparam logic [3:0] ST_DIV_GO = 4'd6;
    localparam logic [3:0] ST_DIV_WAIT = 4'd7;
    localparam logic [3:0] ST_SQ = 4'd8;
    localparam logic [3:0] ST_ACC = 4'd9;
    localparam logic [3:0] ST_RMS_GO = 4'd10;
    localparam logic [3:0] ST_RMS_WAIT = 4'd11;
    localparam logic [3:0] ST_SQRT = 4'd12;
    localparam logic [3:0] ST_OUT = 4'd13;

    localparam logic signed [31:0] RAD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RAD_MIN = 32'sh8000_0000;

    // control
    logic [3:0] state_reg;
    logic [1:0] idx_reg;
    logic [5:0] step_reg;
    logic [NW-1:0] count_reg;
    logic [63:0] sum_reg;

    // payload
    logic signed [epr_pkg::LAT_W-1:0] lat_reg [4];
    logic signed [AW-1:0] ang_reg [4];
    logic last_reg;
    logic signed [TW-1:0] cx_reg, sx_reg, cy_reg, sy_reg, sdx_reg, sdy_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [65:0] hold_reg;
    logic signed [31:0] den_reg;
    logic [33:0] magx_reg, magy_reg;
    logic signed [63:0] prodx_reg, prody_reg;
    logic signed [31:0] radx_reg, rady_reg;
    logic fault_reg;
    logic [63:0] sqx_reg, sqy_reg, tmp_reg;
    logic [63:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [30:0] rms_reg;

    // shared units
    logic cor_start, cor_vec, cor_busy, cor_done;
    logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
    logic signed [AW-1:0] cor_z0, cor_z;
    logic div_start, div_busy, div_done;
    logic [63:0] div_a, div_q;
    logic [31:0] div_b;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    // misc combinational
    logic [30:0] hsel;
    logic signed [AW1-1:0] rot_sum;
    logic signed [32:0] arm_a, arm_b;
    logic signed [65:0] hdiff;
    logic signed [63:0] p_sel;
    logic [63:0] p_mag;
    logic [31:0] den_mag;
    logic signed [31:0] rad_div;
    logic signed [31:0] rad_sat;
    logic [32:0] mx, my;
    logic [64:0] acc_a, acc_b;
    logic [63:0] sq_rb, sq_r_next;
    logic sq_ge;

    function automatic logic [33:0] abs_q28(input logic signed [65:0] d);
        logic signed [37:0] s;
        s = d[65:28];
        return s[37] ? 34'(-s) : 34'(s);
    endfunction

    function automatic logic [32:0] err_mag(input logic [30:0] r, input logic signed [31:0] v);
        logic signed [32:0] e;
        e = $signed({2'b00, r}) - 33'(v);
        return e[32] ? 33'(-e) : 33'(e);
    endfunction

    epr_cordic #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .vec_mode(cor_vec),
        .x0      (cor_x0),
        .y0      (cor_y0),
        .z0      (cor_z0),
        .busy    (cor_busy),
        .done    (cor_done),
        .x       (cor_x),
        .y       (cor_y),
        .z       (cor_z)
    );

    epr_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_a),
        .divisor (div_b),
        .busy    (div_busy),
        .done    (div_done),
        .quotient(div_q)
    );

    // geometry arms and emitter distance per axis
    assign arm_a = 33'($signed({1'b0, dist_x})) - 33'(off_y);
    assign arm_b = 33'($signed({1'b0, dist_y})) - 33'(off_x);
    assign hsel = idx_reg[1] ? dist_y : dist_x;

    // half sum and half difference of the edge angles
    always_comb
    begin
        case (idx_reg)
            2'd0:    rot_sum = AW1'(ang_reg[1]) + AW1'(ang_reg[0]);
            2'd1:    rot_sum = AW1'(ang_reg[3]) + AW1'(ang_reg[2]);
            2'd2:    rot_sum = AW1'(ang_reg[1]) - AW1'(ang_reg[0]);
            default: rot_sum = AW1'(ang_reg[3]) - AW1'(ang_reg[2]);
        endcase
    end

    // shared multiplier, registered product
    assign mul_p = mul_a * mul_b;
    assign hdiff = hold_reg - prod_reg[65:0];

    // radius division operands and result
    assign p_sel = idx_reg[0] ? prody_reg : prodx_reg;
    assign p_mag = p_sel[63] ? 64'(-p_sel) : 64'(p_sel);
    assign den_mag = den_reg[31] ? 32'(-den_reg) : 32'(den_reg);
    assign rad_sat = p_sel[63] ? RAD_MIN : RAD_MAX;
    always_comb
    begin
        if (!p_sel[63])
        begin
            rad_div = (div_q > 64'h7FFF_FFFF) ? RAD_MAX : $signed(div_q[31:0]);
        end
        else
        begin
            rad_div = (div_q >= 64'h8000_0000) ? RAD_MIN : -$signed(div_q[31:0]);
        end
    end

    // error magnitudes and saturating accumulation
    assign mx = err_mag(ref_radius, radx_reg);
    assign my = err_mag(ref_radius, rady_reg);
    assign acc_a = {1'b0, sum_reg} + {1'b0, sqx_reg};
    assign acc_b = {1'b0, tmp_reg} + {1'b0, sqy_reg};

    // square root step
    assign sq_rb = sq_r_reg + sq_bit_reg;
    assign sq_ge = (sq_v_reg >= sq_rb);
    assign sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);

    // sequencer outputs
    always_comb
    begin
        mid_pop = 1'b0;
        out_wr = 1'b0;
        cor_start = 1'b0;
        cor_vec = 1'b0;
        cor_x0 = epr_pkg::GAIN_Q30;
        cor_y0 = '0;
        cor_z0 = '0;
        div_start = 1'b0;
        div_a = p_mag;
        div_b = den_mag;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mid_pop = !mid_empty && !out_full;
            end
            ST_VEC_GO:
            begin
                cor_start = 1'b1;
                cor_vec = 1'b1;
                cor_x0 = $signed({9'b0, hsel, 16'b0});
                cor_y0 = $signed({{7{lat_reg[idx_reg][32]}}, lat_reg[idx_reg], 16'b0});
            end
            ST_ROT_GO:
            begin
                cor_start = 1'b1;
                cor_z0 = rot_sum[AW:1];
            end
            ST_DIV_GO:
            begin
                div_start = (den_reg != '0);
            end
            ST_RMS_GO:
            begin
                div_start = (count_reg != '0);
                div_a = sum_reg;
                div_b = {26'b0, count_reg, 1'b0};
            end
            ST_MUL:
            begin
                case (step_reg[2:0])
                    3'd0:
                    begin
                        mul_a = MW'(cx_reg);
                        mul_b = MW'(cy_reg);
                    end
                    3'd1:
                    begin
                        mul_a = MW'(sx_reg);
                        mul_b = MW'(sy_reg);
                    end
                    3'd2:
                    begin
                        mul_a = MW'(arm_a);
                        mul_b = MW'(cy_reg);
                    end
                    3'd3:
                    begin
                        mul_a = MW'(arm_b);
                        mul_b = MW'(sy_reg);
                    end
                    3'd4:
                    begin
                        mul_a = MW'(arm_b);
                        mul_b = MW'(cx_reg);
                    end
                    3'd5:
                    begin
                        mul_a = MW'(arm_a);
                        mul_b = MW'(sx_reg);
                    end
                    3'd6:
                    begin
                        mul_a = $signed({1'b0, magx_reg});
                        mul_b = MW'(sdx_reg);
                    end
                    default:
                    begin
                        mul_a = $signed({1'b0, magy_reg});
                        mul_b = MW'(sdy_reg);
                    end
                endcase
            end
            ST_SQ:
            begin
                mul_a = step_reg[0] ? $signed({2'b0, my}) : $signed({2'b0, mx});
                mul_b = mul_a;
            end
            ST_OUT:
            begin
                out_wr = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // result beat
    always_comb
    begin
        out_item.radius_x = radx_reg;
        out_item.radius_y = rady_reg;
        out_item.rms_error = last_reg ? rms_reg : '0;
        out_item.rms_valid = last_reg;
        out_item.math_fault = fault_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                if (mid_pop)
                begin
                    lat_reg[0] <= mid_item.lat_fx;
                    lat_reg[1] <= mid_item.lat_lx;
                    lat_reg[2] <= mid_item.lat_fy;
                    lat_reg[3] <= mid_item.lat_ly;
                    last_reg <= mid_item.last_point;
                    fault_reg <= 1'b0;
                end
            end
            ST_VEC_WAIT:
            begin
                if (cor_done)
                begin
                    ang_reg[idx_reg] <= cor_z;
                end
            end
            ST_ROT_WAIT:
            begin
                if (cor_done)
                begin
                    case (idx_reg)
                        2'd0:
                        begin
                            cx_reg <= cor_x[33:2];
                            sx_reg <= cor_y[33:2];
                        end
                        2'd1:
                        begin
                            cy_reg <= cor_x[33:2];
                            sy_reg <= cor_y[33:2];
                        end
                        2'd2:    sdx_reg <= cor_y[33:2];
                        default: sdy_reg <= cor_y[33:2];
                    endcase
                end
            end
            ST_MUL:
            begin
                case (step_reg[3:0])
                    4'd1:    hold_reg <= prod_reg[65:0];
                    4'd2:    den_reg <= hdiff[59:28];
                    4'd3:    hold_reg <= prod_reg[65:0];
                    4'd4:    magx_reg <= abs_q28(hdiff);
                    4'd5:    hold_reg <= prod_reg[65:0];
                    4'd6:    magy_reg <= abs_q28(hdiff);
                    4'd7:    prodx_reg <= prod_reg[63:0];
                    4'd8:    prody_reg <= prod_reg[63:0];
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV_GO:
            begin
                if (den_reg == '0)
                begin
                    fault_reg <= 1'b1;
                    if (idx_reg[0])
                    begin
                        rady_reg <= rad_sat;
                    end
                    else
                    begin
                        radx_reg <= rad_sat;
                    end
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (idx_reg[0])
                    begin
                        rady_reg <= rad_div;
                    end
                    else
                    begin
                        radx_reg <= rad_div;
                    end
                end
            end
            ST_SQ:
            begin
                if (step_reg[1:0] == 2'd1)
                begin
                    sqx_reg <= prod_reg[63:0];
                end
                if (step_reg[1:0] == 2'd2)
                begin
                    sqy_reg <= prod_reg[63:0];
                end
            end
            ST_ACC:
            begin
                if (!step_reg[0])
                begin
                    tmp_reg <= acc_a[64] ? '1 : acc_a[63:0];
                end
            end
            ST_RMS_GO:
            begin
                rms_reg <= '0;
            end
            ST_RMS_WAIT:
            begin
                if (div_done)
                begin
                    sq_v_reg <= div_q;
                    sq_r_reg <= '0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                end
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_v_reg <= sq_v_reg - sq_rb;
                end
                sq_r_reg <= sq_r_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (step_reg == 6'd31)
                begin
                    rms_reg <= (sq_r_next > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sq_r_next[30:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            step_reg <= '0;
            count_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (mid_pop)
                    begin
                        idx_reg <= '0;
                        state_reg <= ST_VEC_GO;
                    end
                end
                ST_VEC_GO:
                begin
                    state_reg <= ST_VEC_WAIT;
                end
                ST_VEC_WAIT:
                begin
                    if (cor_done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= (idx_reg == 2'd3) ? ST_ROT_GO : ST_VEC_GO;
                    end
                end
                ST_ROT_GO:
                begin
                    state_reg <= ST_ROT_WAIT;
                end
                ST_ROT_WAIT:
                begin
                    if (cor_done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        step_reg <= '0;
                        state_reg <= (idx_reg == 2'd3) ? ST_MUL : ST_ROT_GO;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd8)
                    begin
                        step_reg <= '0;
                        idx_reg <= '0;
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO:
                begin
                    if (den_reg != '0)
                    begin
                        state_reg <= ST_DIV_WAIT;
                    end
                    else if (idx_reg[0])
                    begin
                        step_reg <= '0;
                        state_reg <= ST_SQ;
                    end
                    else
                    begin
                        idx_reg <= 2'd1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (idx_reg[0])
                        begin
                            step_reg <= '0;
                            state_reg <= ST_SQ;
                        end
                        else
                        begin
                            idx_reg <= 2'd1;
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_SQ:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd2)
                    begin
                        step_reg <= '0;
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg[0])
                    begin
                        step_reg <= '0;
                        if (count_reg < NW'(MAX_POINTS))
                        begin
                            sum_reg <= acc_b[64] ? '1 : acc_b[63:0];
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= last_reg ? ST_RMS_GO : ST_OUT;
                    end
                end
                ST_RMS_GO:
                begin
                    state_reg <= (count_reg != '0) ? ST_RMS_WAIT : ST_OUT;
                end
                ST_RMS_WAIT:
                begin
                    if (div_done)
                    begin
                        step_reg <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd31)
                    begin
                        step_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (last_reg)
                    begin
                        sum_reg <= '0;
                        count_reg <= '0;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an item is only taken when its result has a slot waiting
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !out_full)
        else $error("item taken while result queue full");

    // a result slot reserved at start is still free at the end
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_wr |-> !out_full)
        else $error("result written into full queue");

    a_cordic_free: assert property (@(posedge clk) disable iff (!rst_n)
        cor_start |-> !cor_busy)
        else $error("cordic restarted while busy");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_POINTS))
        else $error("point count past set limit");

endmodule

>>> rtl/edge_pair_radius_rms_error_top.sv
// Shadow-edge radius estimator with running RMS error against a reference.
// Input channel: push/full, a beat carries the front and fall edges of both
// axes and the last-of-set mark; a beat is taken when push is high and full is low.
// Result channel: empty/pop, one result beat for every input beat, in
// order: both axis radii, the fault flag, and on the last beat of a set the
// RMS error with rms_valid set. The head result is held on result while
// empty is low and leaves on a cycle with pop high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high, registers are to be written only while no item is in flight.
// Engine: one shared iterative CORDIC (one step a cycle), one shared 64-step
// divider and a 32-step square root set the rate; a last item also runs
// the mean divide and square root.
// Items are worked one at a time; a two-entry queue in front of the engine
// and another behind it let the source and the sink stall on their own.
// When the sink stalls the engine finishes its item and waits for a free
// result slot before taking the next one.
// Reset clears the running sum and count, empties both queues and loads
// the register defaults.
module edge_pair_radius_rms_error_top #(
    parameter int MAX_POINTS = epr_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_ITERATIONS = epr_pkg::CORDIC_ITER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  epr_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output epr_pkg::res_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic [23:0]        centre_x_reg;
    logic [23:0]        centre_y_reg;
    logic [30:0]        dist_x_reg;
    logic [30:0]        dist_y_reg;
    logic signed [31:0] off_x_reg;
    logic signed [31:0] off_y_reg;
    logic [23:0]        pitch_reg;
    logic [30:0]        ref_reg;

    logic               mid_wr;
    logic               mid_full;
    logic               mid_empty;
    logic               mid_pop;
    epr_pkg::mid_item_t mid_in;
    epr_pkg::mid_item_t mid_out;
    logic               out_wr;
    logic               out_full;
    epr_pkg::res_item_t out_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            dist_x_reg <= 31'd1;
            dist_y_reg <= 31'd1;
            off_x_reg <= '0;
            off_y_reg <= '0;
            pitch_reg <= 24'd65536;
            ref_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                epr_pkg::CFG_CENTRE_X:   centre_x_reg <= cfg_data[23:0];
                epr_pkg::CFG_CENTRE_Y:   centre_y_reg <= cfg_data[23:0];
                epr_pkg::CFG_DIST_X:     dist_x_reg <= cfg_data[30:0];
                epr_pkg::CFG_DIST_Y:     dist_y_reg <= cfg_data[30:0];
                epr_pkg::CFG_OFFSET_X:   off_x_reg <= $signed(cfg_data);
                epr_pkg::CFG_OFFSET_Y:   off_y_reg <= $signed(cfg_data);
                epr_pkg::CFG_PITCH:      pitch_reg <= cfg_data[23:0];
                epr_pkg::CFG_REF_RADIUS: ref_reg <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    epr_front u_front (
        .push    (push),
        .full    (full),
        .item    (item),
        .centre_x(centre_x_reg),
        .centre_y(centre_y_reg),
        .pitch   (pitch_reg),
        .mid_full(mid_full),
        .mid_wr  (mid_wr),
        .mid_item(mid_in)
    );

    epr_fifo #(
        .WIDTH($bits(epr_pkg::mid_item_t)),
        .DEPTH(2)
    ) u_mid_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (mid_wr),
        .wr_data(mid_in),
        .full   (mid_full),
        .rd     (mid_pop),
        .rd_data(mid_out),
        .empty  (mid_empty)
    );

    epr_back #(
        .MAX_POINTS       (MAX_POINTS),
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_out),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_item  (out_item),
        .dist_x    (dist_x_reg),
        .dist_y    (dist_y_reg),
        .off_x     (off_x_reg),
        .off_y     (off_y_reg),
        .ref_radius(ref_reg)
    );

    epr_fifo #(
        .WIDTH($bits(epr_pkg::res_item_t)),
        .DEPTH(2)
    ) u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (out_wr),
        .wr_data(out_item),
        .full   (out_full),
        .rd     (pop),
        .rd_data(result),
        .empty  (empty)
    );

endmodule

>>> verif/edge_pair_radius_rms_error_top_tb.sv
module edge_pair_radius_rms_error_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_LIMIT = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int ITEM_CYCLES = 8 * (CORDIC_STEPS + 2) + 260;
    localparam longint CYCLE_LIMIT = 4000000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    epr_pkg::in_item_t  item;
    logic               empty;
    logic               pop;
    epr_pkg::res_item_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [3:0]         cfg_index;
    logic [31:0]        cfg_data;

    edge_pair_radius_rms_error_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // sensor geometry mirror
    longint unsigned geo_cpx, geo_cpy, geo_dist_x, geo_dist_y, geo_pitch, geo_ref;
    longint          geo_off_x, geo_off_y;
    // running error accumulation
    longint unsigned err_sum;
    int              err_points;

    epr_pkg::res_item_t expected_radii[$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_idle_pct;
    longint    cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint arc_step(int i);
        longint tab[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11)
            return tab[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    // atan2 of lateral over distance, Q30
    function automatic longint edge_angle(longint across, longint along);
        longint px, py, ang, tx, ty;
        px = across * 65536;
        py = along * 65536;
        ang = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            tx = px >>> i;
            ty = py >>> i;
            if (py < 0)
            begin
                px -= ty; py += tx; ang -= arc_step(i);
            end
            else
            begin
                px += ty; py -= tx; ang += arc_step(i);
            end
        end
        return ang;
    endfunction

    // cos and sin, Q28
    task automatic sin_cos(input longint ang, output longint c, output longint s);
        longint px, py, tx, ty;
        px = 652032874;
        py = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            tx = px >>> i;
            ty = py >>> i;
            if (ang >= 0)
            begin
                px -= ty; py += tx; ang -= arc_step(i);
            end
            else
            begin
                px += ty; py -= tx; ang += arc_step(i);
            end
        end
        c = px >>> 2;
        s = py >>> 2;
    endtask

    function automatic longint edge_offset(logic [23:0] e, longint unsigned centre);
        longint d;
        d = longint'({40'd0, e}) - longint'(centre);
        return (d * longint'(geo_pitch)) >>> 16;
    endfunction

    task automatic axis_length(input longint num, input longint sin_half, input longint den,
                               inout bit fault, output logic [31:0] r);
        longint mag, prod;
        longint unsigned q, dmag;
        mag = num >>> 28;
        if (mag < 0)
            mag = -mag;
        prod = mag * sin_half;
        if (den == 0)
        begin
            fault = 1'b1;
            r = (prod >= 0) ? 32'h7fffffff : 32'h80000000;
        end
        else
        begin
            dmag = (den < 0) ? -den : den;
            if (prod >= 0)
            begin
                q = longint'(prod) / dmag;
                r = (q > 64'h7fffffff) ? 32'h7fffffff : q[31:0];
            end
            else
            begin
                q = longint'(-prod) / dmag;
                r = (q >= 64'h80000000) ? 32'h80000000 : -q[31:0];
            end
        end
    endtask

    function automatic longint unsigned radius_err_sq(logic signed [31:0] r);
        longint e;
        longint unsigned m;
        e = longint'(geo_ref) - longint'(r);
        m = (e < 0) ? -e : e;
        return m * m;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000000000000000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
        logic [64:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[64] ? 64'hffffffffffffffff : t[63:0];
    endfunction

    // radii, fault and set error for one accepted beat
    task automatic predict_radii(input epr_pkg::in_item_t it);
        longint hx, hy, a1, a2, b1, b2, cx, sx, cy, sy, cdx, sdx, cdy, sdy, den, arm_a, arm_b;
        longint unsigned div, rms;
        bit fault;
        epr_pkg::res_item_t res;
        hx = longint'(geo_dist_x);
        hy = longint'(geo_dist_y);
        a1 = edge_angle(hx, edge_offset(it.front_edge_x, geo_cpx));
        a2 = edge_angle(hx, edge_offset(it.fall_edge_x, geo_cpx));
        b1 = edge_angle(hy, edge_offset(it.front_edge_y, geo_cpy));
        b2 = edge_angle(hy, edge_offset(it.fall_edge_y, geo_cpy));
        sin_cos((a1 + a2) >>> 1, cx, sx);
        sin_cos((b1 + b2) >>> 1, cy, sy);
        sin_cos((a2 - a1) >>> 1, cdx, sdx);
        sin_cos((b2 - b1) >>> 1, cdy, sdy);
        den = (cx * cy - sx * sy) >>> 28;
        arm_a = hx - geo_off_y;
        arm_b = hy - geo_off_x;
        fault = 1'b0;
        res = '0;
        axis_length(arm_a * cy - arm_b * sy, sdx, den, fault, res.radius_x);
        axis_length(arm_b * cx - arm_a * sx, sdy, den, fault, res.radius_y);
        if (err_points < SET_LIMIT)
        begin
            err_sum = sat_add(err_sum, radius_err_sq(res.radius_x));
            err_sum = sat_add(err_sum, radius_err_sq(res.radius_y));
            err_points++;
        end
        if (it.last_point)
        begin
            div = 2 * err_points;
            rms = 0;
            if (div != 0)
            begin
                rms = floor_sqrt(err_sum / div);
                if (rms > 64'h7fffffff)
                    rms = 64'h7fffffff;
            end
            res.rms_error = rms[30:0];
            res.rms_valid = 1'b1;
            err_sum = 0;
            err_points = 0;
        end
        res.math_fault = fault;
        expected_radii.push_back(res);
    endtask

    // result side: random pop, compare each beat
    always @(posedge clk)
    begin
        epr_pkg::res_item_t want;
        pop <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && !empty && pop)
        begin
            if (expected_radii.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat rx=%h ry=%h", result.radius_x,
                             result.radius_y);
            end
            else
            begin
                want = expected_radii.pop_front();
                if (result.radius_x !== want.radius_x || result.radius_y !== want.radius_y
                    || result.rms_error !== want.rms_error
                    || result.rms_valid !== want.rms_valid
                    || result.math_fault !== want.math_fault)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch exp rx=%h ry=%h rms=%h v=%b f=%b",
                               want.radius_x, want.radius_y, want.rms_error,
                               want.rms_valid, want.math_fault);
                        $display(" got rx=%h ry=%h rms=%h v=%b f=%b",
                                 result.radius_x, result.radius_y, result.rms_error,
                                 result.rms_valid, result.math_fault);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input epr_pkg::in_item_t it);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_radii(it);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (expected_radii.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            epr_pkg::CFG_CENTRE_X:   geo_cpx = val[23:0];
            epr_pkg::CFG_CENTRE_Y:   geo_cpy = val[23:0];
            epr_pkg::CFG_DIST_X:     geo_dist_x = val[30:0];
            epr_pkg::CFG_DIST_Y:     geo_dist_y = val[30:0];
            epr_pkg::CFG_OFFSET_X:   geo_off_x = longint'(signed'(val));
            epr_pkg::CFG_OFFSET_Y:   geo_off_y = longint'(signed'(val));
            epr_pkg::CFG_PITCH:      geo_pitch = val[23:0];
            epr_pkg::CFG_REF_RADIUS: geo_ref = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [31:0] cpx, input logic [31:0] cpy,
                                input logic [31:0] dx, input logic [31:0] dy,
                                input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] pitch, input logic [31:0] rref);
        wait_drained();
        write_reg(epr_pkg::CFG_CENTRE_X, cpx);
        write_reg(epr_pkg::CFG_CENTRE_Y, cpy);
        write_reg(epr_pkg::CFG_DIST_X, dx);
        write_reg(epr_pkg::CFG_DIST_Y, dy);
        write_reg(epr_pkg::CFG_OFFSET_X, ox);
        write_reg(epr_pkg::CFG_OFFSET_Y, oy);
        write_reg(epr_pkg::CFG_PITCH, pitch);
        write_reg(epr_pkg::CFG_REF_RADIUS, rref);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic epr_pkg::in_item_t make_item(logic [23:0] fx, logic [23:0] lx,
                                                    logic [23:0] fy, logic [23:0] ly,
                                                    logic last);
        epr_pkg::in_item_t it;
        it.front_edge_x = fx;
        it.fall_edge_x = lx;
        it.front_edge_y = fy;
        it.fall_edge_y = ly;
        it.last_point = last;
        return it;
    endfunction

    // shadow edges near the centre pixel most of the time, anywhere otherwise
    function automatic logic [23:0] shadow_edge(longint unsigned centre);
        if ($urandom_range(99) < 65)
            return 24'(centre + $urandom_range(0, 16384) - 8192);
        return 24'($urandom);
    endfunction

    function automatic epr_pkg::in_item_t random_item();
        return make_item(shadow_edge(geo_cpx), shadow_edge(geo_cpx), shadow_edge(geo_cpy),
                         shadow_edge(geo_cpy), $urandom_range(99) < 12);
    endfunction

    task automatic test_field_extremes();
        send_item(make_item(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0));
        send_item(make_item(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 1'b0));
        send_item(make_item(24'h000000, 24'hffffff, 24'hffffff, 24'h000000, 1'b0));
        send_item(make_item(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 1'b1));
        // last beat alone in its set
        send_item(make_item(24'h001000, 24'h002000, 24'h001000, 24'h002000, 1'b1));
    endtask

    task automatic test_realistic_set();
        set_geometry(32'd512 << 8, 32'd480 << 8, 32'd2000 << 8, 32'd1800 << 8,
                     -(32'd300 << 8), 32'd250 << 8, 32'd655, 32'd20 << 8);
        for (int i = 0; i < 5; i++)
            send_item(make_item(24'(131072 - 900 - 40 * i), 24'(131072 + 700 + 30 * i),
                                24'(122880 - 800), 24'(122880 + 850 + 20 * i), i == 4));
    endtask

    // set overrun: items past the point limit give radii but do not count
    task automatic test_set_overrun();
        for (int i = 0; i < SET_LIMIT + 4; i++)
            send_item(make_item(24'(131072 - $urandom_range(2000)),
                                24'(131072 + $urandom_range(2000)),
                                24'(122880 - $urandom_range(2000)),
                                24'(122880 + $urandom_range(2000)), i == SET_LIMIT + 3));
    endtask

    // centre directions summing to a right angle, near zero denominator
    task automatic test_degenerate_geometry();
        set_geometry(32'd0, 32'h800000, 32'd1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                     32'hffffff, 32'h7fffffff);
        send_item(make_item(24'hffffff, 24'hfffff0, 24'h800000, 24'h800000, 1'b0));
        send_item(make_item(24'hffffff, 24'hffffff, 24'h800001, 24'h7fffff, 1'b0));
        send_item(make_item(24'h000000, 24'hffffff, 24'h000000, 24'hffffff, 1'b1));
        set_geometry(32'hffffff, 32'd0, 32'h7fffffff, 32'd1, 32'h80000000, 32'h7fffffff,
                     32'd1, 32'd0);
        send_item(make_item(24'h000000, 24'hffffff, 24'hffffff, 24'hffffff, 1'b0));
        send_item(make_item(24'hfffffe, 24'h000001, 24'h000000, 24'h000000, 1'b1));
    endtask

    task automatic random_geometry();
        if ($urandom_range(3) == 0)
            set_geometry($urandom, $urandom, $urandom_range(1, 32'h7fffffff),
                         $urandom_range(1, 32'h7fffffff), $urandom, $urandom,
                         $urandom_range(1, 24'hffffff), $urandom);
        else
            set_geometry($urandom_range(256, 4096) << 8, $urandom_range(256, 4096) << 8,
                         $urandom_range(100, 20000) << 8, $urandom_range(100, 20000) << 8,
                         $urandom_range(0, 2000 << 8) - (1000 << 8),
                         $urandom_range(0, 2000 << 8) - (1000 << 8),
                         $urandom_range(64, 1 << 18), $urandom_range(0, 200 << 8));
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % 110 == 0)
                random_geometry();
            send_item(random_item());
        end
        send_item(make_item(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 1'b1));
    endtask

    // sender holds off until all results are back, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 6; i++)
            send_item(random_item());
        wait_drained();
        for (int i = 0; i < 6; i++)
            send_item(random_item());
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 25;
        recv_idle_pct = 50;
        geo_cpx = 0;
        geo_cpy = 0;
        geo_dist_x = 1;
        geo_dist_y = 1;
        geo_off_x = 0;
        geo_off_y = 0;
        geo_pitch = 65536;
        geo_ref = 0;
        err_sum = 0;
        err_points = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_realistic_set();
        test_set_overrun();
        test_degenerate_geometry();
        test_random_traffic(25, 50, 440);
        test_drain_pause();
        test_random_traffic(50, 25, 440);
        test_random_traffic(0, 0, 440);

        wait_drained();
        repeat (ITEM_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_radii.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> edge_pair_radius_rms_error_top.f
rtl/epr_pkg.sv
rtl/epr_fifo.sv
rtl/epr_front.sv
rtl/epr_cordic.sv
rtl/epr_divider.sv
rtl/epr_back.sv
rtl/edge_pair_radius_rms_error_top.sv
verif/edge_pair_radius_rms_error_top_tb.sv
